// File: rtl/core/wlp_pkg.sv
// package for the weighted lottery picker with timer
// holds item structs, function codes, controller states and command/status structs
package wlp_pkg;

  localparam int unsigned MsPerSec   = 1000;
  localparam int unsigned MaxEntries = 16;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_FORCE = 2'd1,
    FUNC_LOAD  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic [3:0]  entry_index;
    logic [15:0] entry_weight;
    logic [15:0] entry_min_sec;
    logic [15:0] entry_max_sec;
    logic [31:0] random_roll;
    logic [31:0] random_duration;
    logic [31:0] random_preview;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  current_index;
    logic [3:0]  next_index;
    logic [25:0] duration_ms;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SUM_CUR,
    ST_MOD_CUR,
    ST_SCAN_CUR,
    ST_SPAN,
    ST_MOD_DUR,
    ST_MUL_DUR,
    ST_SUM_PRV,
    ST_MOD_PRV,
    ST_SCAN_PRV,
    ST_OUT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic load;      // write the table entry
    logic clr_walk;  // restart the entry walk
    logic sum_step;  // accumulate one weight
    logic mod_start; // start the divider
    logic scan_step; // compare/subtract one weight
    logic prv_phase; // walk runs for the preview
    logic dur_phase; // divider runs for the duration
    logic set_span;  // prepare duration span
    logic commit_cur;// write current entry and start time
    logic mul_dur;   // scale seconds to ms
    logic set_out;   // load output register
  } cmd_t;

  typedef struct packed {
    logic       is_load;
    logic       do_pick;
    logic       walk_done;
    logic       total_zero;
    logic       mod_done;
    logic       scan_hit;
    logic       span_zero;
  } sts_t;

endpackage

// File: rtl/core/wlp_datapath.sv
// datapath of the lottery picker: entry tables, walk counter, divider, timer
// depends on wlp_pkg
module wlp_datapath import wlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  logic [4:0] entry_count_i,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  output out_item_t res_o
);
  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  logic [15:0] weight_q [MaxEntries];
  logic [15:0] min_q    [MaxEntries];
  logic [15:0] max_q    [MaxEntries];

  in_item_t    item_q;
  logic [3:0]  cur_q;
  logic [31:0] start_q;
  logic [25:0] run_q;
  logic        started_q;

  logic [CntW-1:0] walk_q;
  logic [31:0]     total_q;
  logic            skip_en_q;
  logic [3:0]      skip_idx_q;
  logic [IdxW-1:0] hit_q;
  logic [16:0]     span_q;
  logic [15:0]     secs_q;

  // restoring divider, one bit per cycle
  logic [31:0] dvd_q, div_q;
  logic [32:0] rem_q;
  logic [5:0]  dcnt_q;
  logic        dbusy_q;

  out_item_t res_q;

  // used entry count, clamped to 1..MaxEntries
  logic [CntW-1:0] n_used;
  always_comb begin
    if (entry_count_i == 5'd0) begin
      n_used = CntW'(1);
    end else if (32'(entry_count_i) > 32'(MaxEntries)) begin
      n_used = CntW'(MaxEntries);
    end else begin
      n_used = CntW'(entry_count_i);
    end
  end

  logic [IdxW-1:0] widx;
  logic [15:0]     wcur;
  logic            skip_here;
  logic            scan_hit;
  assign widx      = walk_q[IdxW-1:0];
  assign wcur      = weight_q[widx];
  assign skip_here = skip_en_q && (32'(walk_q) == 32'(skip_idx_q));
  assign scan_hit  = !skip_here && (rem_q[31:0] < 32'(wcur));

  // restoring step
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem_q[31:0], dvd_q[31]};
  assign rem_sub = rem_sh - {1'b0, div_q};

  logic [IdxW-1:0] cur_idx;
  assign cur_idx = IdxW'(cur_q);

  // preview hit is taken straight from the walk when it lands in the output cycle
  logic [3:0] nxt_idx;
  assign nxt_idx = (total_q == 32'd0) ? cur_q :
                   ((cmd_i.scan_step && scan_hit) ? 4'(widx) : 4'(hit_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxEntries; i++) begin
        weight_q[i] <= '0;
        min_q[i]    <= '0;
        max_q[i]    <= '0;
      end
      cur_q     <= '0;
      start_q   <= '0;
      run_q     <= '0;
      started_q <= 1'b0;
      walk_q    <= '0;
      total_q   <= '0;
      skip_en_q <= 1'b0;
      skip_idx_q<= '0;
      hit_q     <= '0;
      span_q    <= '0;
      secs_q    <= '0;
      dvd_q     <= '0;
      div_q     <= '0;
      rem_q     <= '0;
      dcnt_q    <= '0;
      dbusy_q   <= 1'b0;
      res_q     <= '0;
    end else begin
      if (cmd_i.load && (32'(item_q.entry_index) < 32'(MaxEntries))) begin
        weight_q[IdxW'(item_q.entry_index)] <= item_q.entry_weight;
        min_q[IdxW'(item_q.entry_index)]    <= item_q.entry_min_sec;
        max_q[IdxW'(item_q.entry_index)]    <= item_q.entry_max_sec;
      end
      if (cmd_i.clr_walk) begin
        walk_q  <= '0;
        total_q <= '0;
        hit_q   <= '0;
        if (cmd_i.prv_phase) begin
          skip_en_q  <= 1'b1;
          skip_idx_q <= cur_q;
        end else begin
          skip_en_q  <= started_q && (n_used > CntW'(1));
          skip_idx_q <= cur_q;
        end
      end
      if (cmd_i.sum_step) begin
        if (!skip_here) total_q <= total_q + 32'(wcur);
        walk_q <= walk_q + CntW'(1);
      end
      if (cmd_i.mod_start) begin
        dvd_q   <= cmd_i.dur_phase ? item_q.random_duration :
                   (cmd_i.prv_phase ? item_q.random_preview : item_q.random_roll);
        div_q   <= cmd_i.dur_phase ? 32'(span_q) : total_q;
        rem_q   <= '0;
        dcnt_q  <= '0;
        dbusy_q <= 1'b1;
        walk_q  <= '0;
      end else if (dbusy_q) begin
        dvd_q <= {dvd_q[30:0], 1'b0};
        rem_q <= rem_sub[32] ? rem_sh : rem_sub;
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd31) dbusy_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (!skip_here) begin
          if (rem_q[31:0] < 32'(wcur)) hit_q <= widx;
          else rem_q <= rem_q - 33'(wcur);
        end
        walk_q <= walk_q + CntW'(1);
      end
      if (cmd_i.set_span) begin
        span_q <= 17'(max_q[cur_idx]) - 17'(min_q[cur_idx]) + 17'd1;
        secs_q <= min_q[cur_idx];
      end
      if (cmd_i.commit_cur) begin
        cur_q     <= (total_q == 32'd0) ? 4'd0 : 4'(hit_q);
        start_q   <= item_q.now_ms;
        started_q <= 1'b1;
      end
      if (cmd_i.mul_dur) begin
        // secs plus remainder fits 16 bits since the sum stays at most max
        run_q <= 26'((secs_q + (cmd_i.dur_phase ? rem_q[15:0] : 16'd0)) * 26'(MsPerSec));
      end
      if (cmd_i.set_out) begin
        res_q.current_index <= cur_q;
        res_q.next_index    <= nxt_idx;
        res_q.duration_ms   <= run_q;
      end
    end
  end

  logic        expired;
  assign expired = (item_q.now_ms - start_q) >= 32'(run_q);

  // scan hit: current compare succeeds on a non-skipped entry
  assign sts_o.is_load    = (item_q.func == FUNC_LOAD);
  assign sts_o.do_pick    = (item_q.func == FUNC_FORCE) ||
                            ((item_q.func == FUNC_TICK) && (!started_q || expired));
  assign sts_o.walk_done  = (walk_q >= n_used);
  assign sts_o.total_zero = (total_q == 32'd0);
  assign sts_o.mod_done   = !dbusy_q;
  assign sts_o.scan_hit   = scan_hit;
  assign sts_o.span_zero  = (max_q[cur_idx] <= min_q[cur_idx]);
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start && cmd_i.dur_phase) begin
      assert (span_q != 17'd0) else $error("zero duration span");
    end
  end

endmodule

// File: rtl/core/wlp_ctrl.sv
// controller state machine of the lottery picker
// depends on wlp_pkg
module wlp_ctrl import wlp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  logic   outv_q, outv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      outv_q  <= outv_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = outv_q;

  always_comb begin
    state_d = state_q;
    outv_d  = outv_q && !out_ready_i;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_load) begin
          cmd_o.load = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.do_pick) begin
          cmd_o.clr_walk = 1'b1;
          state_d = ST_SUM_CUR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM_CUR: begin
        if (sts_i.walk_done) begin
          if (sts_i.total_zero) state_d = ST_SPAN;
          else state_d = ST_MOD_CUR;
          if (!sts_i.total_zero) cmd_o.mod_start = 1'b1;
          if (sts_i.total_zero) cmd_o.commit_cur = 1'b1;
        end else begin
          cmd_o.sum_step = 1'b1;
        end
      end
      ST_MOD_CUR: begin
        if (sts_i.mod_done) state_d = ST_SCAN_CUR;
      end
      ST_SCAN_CUR: begin
        if (sts_i.scan_hit || sts_i.walk_done) begin
          cmd_o.scan_step  = !sts_i.walk_done;
          state_d = ST_SPAN;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_SPAN: begin
        // commit happens here for the non-zero total case
        if (!sts_i.total_zero) cmd_o.commit_cur = 1'b1;
        state_d = ST_MOD_DUR;
      end
      ST_MOD_DUR: begin
        cmd_o.set_span = 1'b1;
        state_d = ST_MUL_DUR;
      end
      ST_MUL_DUR: begin
        if (sts_i.span_zero) begin
          cmd_o.mul_dur  = 1'b1;
          cmd_o.clr_walk = 1'b1;
          cmd_o.prv_phase = 1'b1;
          state_d = ST_SUM_PRV;
        end else begin
          cmd_o.mod_start = 1'b1;
          cmd_o.dur_phase = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // waits for duration remainder, then scales it
        if (sts_i.mod_done) begin
          cmd_o.mul_dur   = 1'b1;
          cmd_o.dur_phase = 1'b1;
          cmd_o.clr_walk  = 1'b1;
          cmd_o.prv_phase = 1'b1;
          state_d = ST_SUM_PRV;
        end
      end
      ST_SUM_PRV: begin
        cmd_o.prv_phase = 1'b1;
        if (sts_i.walk_done) begin
          if (sts_i.total_zero) begin
            if (!outv_q || out_ready_i) begin
              cmd_o.set_out = 1'b1;
              outv_d = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            cmd_o.mod_start = 1'b1;
            state_d = ST_MOD_PRV;
          end
        end else begin
          cmd_o.sum_step = 1'b1;
        end
      end
      ST_MOD_PRV: begin
        if (sts_i.mod_done) state_d = ST_SCAN_PRV;
      end
      ST_SCAN_PRV: begin
        cmd_o.prv_phase = 1'b1;
        if (sts_i.scan_hit || sts_i.walk_done) begin
          if (!outv_q || out_ready_i) begin
            cmd_o.scan_step = !sts_i.walk_done;
            cmd_o.set_out = 1'b1;
            outv_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (state_q != ST_IDLE) |-> !in_ready_o;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");

  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE && sts_i.is_load) |=> state_q == ST_IDLE)
    else $error("load not single cycle");

endmodule

// File: rtl/core/weighted_lottery_picker_with_timer_unit.sv
// a load or ignored item is handled in the decode state; a pick runs up to four entry walks
// (over the n entries in use) and up to three bit-serial divisions
// one item at a time; the next item is taken once the current one is done
// a finished result waits in the output register without blocking a new item; a later
// pick holds its own result until that register is free
// reset: tables cleared, entry count 1, nothing picked
module weighted_lottery_picker_with_timer_unit import wlp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [4:0] cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);
  logic [4:0] count_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 5'd1;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  wlp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  wlp_datapath u_dp (
    .clk_i, .rst_ni, .item_i(in_data_i), .entry_count_i(count_q),
    .cmd_i(cmd), .sts_o(sts), .res_o(out_data_o)
  );

endmodule
